FILE: rtl/mffn_pkg.sv
// Package for the maze flood-fill navigator: codes, map entry layout, sequencer states
// and coordinate helpers.
// No dependencies.
package mffn_pkg;

  // coordinates carry two spare bits beyond the 4-bit fields so that a step off the low edge wraps to a large value
  localparam int CoordW = 6;

  localparam logic [7:0] Unreached = 8'd255;
  localparam logic [7:0] MaxLevel  = 8'd254;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_EXPLORE = 2'd1;
  localparam logic [1:0] OP_SPEED   = 2'd2;

  localparam logic [1:0] CFG_GOAL_CENTRE = 2'd0;
  localparam logic [1:0] CFG_START_COL   = 2'd1;
  localparam logic [1:0] CFG_START_ROW   = 2'd2;

  localparam logic [1:0] DIR_WEST  = 2'd0;
  localparam logic [1:0] DIR_NORTH = 2'd1;
  localparam logic [1:0] DIR_EAST  = 2'd2;
  localparam logic [1:0] DIR_SOUTH = 2'd3;

  typedef struct packed {
    logic [3:0] walls;
    logic       visited;
    logic [7:0] flood_dist;
    logic       front_a;
    logic       front_b;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXP_RD,
    ST_EXP_WR,
    ST_NB_CHK,
    ST_NB_WR,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_LVL_RD,
    ST_LVL_EV,
    ST_FN_CHK,
    ST_FN_WR,
    ST_LVL_NEXT,
    ST_CH_RD,
    ST_CH_EV,
    ST_CH_NB,
    ST_CH_CMP,
    ST_CH_END,
    ST_DONE
  } state_t;

  function automatic logic [CoordW-1:0] step_col(input logic [CoordW-1:0] c,
                                                 input logic [1:0] d);
    logic [CoordW-1:0] r;
    r = c;
    if (d == DIR_WEST) r = c - CoordW'(1);
    else if (d == DIR_EAST) r = c + CoordW'(1);
    return r;
  endfunction

  function automatic logic [CoordW-1:0] step_row(input logic [CoordW-1:0] rw,
                                                 input logic [1:0] d);
    logic [CoordW-1:0] r;
    r = rw;
    if (d == DIR_NORTH) r = rw + CoordW'(1);
    else if (d == DIR_SOUTH) r = rw - CoordW'(1);
    return r;
  endfunction

endpackage

FILE: rtl/mffn_map_ram.sv
// Single-port-write, single-port-read map memory with registered read data.
// Depends on nothing; entry layout is chosen by the user.
module mffn_map_ram #(
  parameter int AddrW = 8,
  parameter int DataW = 15
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [DataW-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [DataW-1:0] wr_data
);

  logic [DataW-1:0] mem [2**AddrW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/maze_flood_fill_navigator_core.sv
// Maze flood-fill navigator core: map sequencer around one map memory.
// Depends on mffn_pkg and mffn_map_ram.
//
// One item at a time. All map state (walls, visited mark, distance, two frontier bitmaps)
// sits in one memory with one read and one write per cycle, so every cost is a count of
// memory accesses. After reset and for a clear item the map is rewritten at one cell per
// cycle, during which no item is taken. An explore or speed-run item seeds the flood with
// a read and a write per cell, then sweeps the map once per breadth level, checking and
// marking the open neighbours of each cell reached in that level, with one empty closing
// level; the choice of move then reads each cell along the straight run and compares its
// neighbours. A result waits in the output register while the next item is taken.
module maze_flood_fill_navigator_core
  import mffn_pkg::*;
#(
  parameter int GRID_COLS = 16,
  parameter int GRID_ROWS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cell_col, cell_row, sensed_mask, wall_bits
  input  logic [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // move_dir, run_length, no_path, cell_distance
);

  localparam int AddrW = $clog2(GRID_COLS * GRID_ROWS);
  localparam logic [4:0] RunLimit = (GRID_COLS > 31) ? 5'd31 : 5'(GRID_COLS);
  localparam logic [CoordW-1:0] LastCol = CoordW'(GRID_COLS - 1);
  localparam logic [CoordW-1:0] LastRow = CoordW'(GRID_ROWS - 1);
  localparam logic [CoordW-1:0] CtrColLo = CoordW'(GRID_COLS / 2 - 1);
  localparam logic [CoordW-1:0] CtrColHi = CoordW'(GRID_COLS / 2);
  localparam logic [CoordW-1:0] CtrRowLo = CoordW'(GRID_ROWS / 2 - 1);
  localparam logic [CoordW-1:0] CtrRowHi = CoordW'(GRID_ROWS / 2);

  function automatic logic in_grid(input logic [CoordW-1:0] c, input logic [CoordW-1:0] r);
    return (c <= LastCol) && (r <= LastRow);
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(input logic [CoordW-1:0] c,
                                                 input logic [CoordW-1:0] r);
    logic [2*CoordW-1:0] a;
    a = (2*CoordW)'(r) * (2*CoordW)'(GRID_COLS) + (2*CoordW)'(c);
    return a[AddrW-1:0];
  endfunction

  state_t state, state_next;

  logic              goal_centre;
  logic [3:0]        start_col, start_row;

  logic [1:0]        op;
  logic [CoordW-1:0] in_col, in_row;
  logic [3:0]        sensed, wbits;
  logic [CoordW-1:0] sc, sr, pc, pr;
  logic [1:0]        dcnt;
  logic [3:0]        wreg;
  logic              bank, assigned, first, bv, clr_reply;
  logic [7:0]        level, bd;
  logic [1:0]        bdir;
  logic [1:0]        r_dir;
  logic [4:0]        r_run;
  logic              r_nopath;
  logic [7:0]        r_dist;

  logic              rd_en, wr_en;
  logic [AddrW-1:0]  rd_addr, wr_addr;
  logic [EntryW-1:0] rd_raw;
  entry_t            q, wr_entry;

  logic [CoordW-1:0] base_c, base_r, nb_c, nb_r;
  logic              nb_ok, scan_last, cell_ok, cur_bit, fl_hit, src_hit, run_more;
  logic              sc_wrap;

  assign q         = entry_t'(rd_raw);
  assign cfg_ready = 1'b1;
  assign nb_c      = step_col(base_c, dcnt);
  assign nb_r      = step_row(base_r, dcnt);
  assign nb_ok     = in_grid(nb_c, nb_r);
  assign sc_wrap   = (sc == LastCol);
  assign scan_last = sc_wrap && (sr == LastRow);
  assign cell_ok   = in_grid(in_col, in_row);
  assign cur_bit   = bank ? q.front_b : q.front_a;
  assign fl_hit    = cur_bit && (q.flood_dist == Unreached);
  assign src_hit   = goal_centre ?
                     ((sc == CtrColLo || sc == CtrColHi) && (sr == CtrRowLo || sr == CtrRowHi)) :
                     ((sc == CoordW'(start_col)) && (sr == CoordW'(start_row)));
  assign run_more  = bv && (bdir == r_dir) && (r_run < RunLimit);

  always_comb begin
    unique case (state)
      ST_EXP_RD, ST_EXP_WR, ST_NB_CHK, ST_NB_WR: begin
        base_c = in_col;
        base_r = in_row;
      end
      ST_CH_RD, ST_CH_EV, ST_CH_NB, ST_CH_CMP, ST_CH_END: begin
        base_c = pc;
        base_r = pr;
      end
      default: begin
        base_c = sc;
        base_r = sr;
      end
    endcase
  end

  mffn_map_ram #(
    .AddrW (AddrW),
    .DataW (EntryW)
  ) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (scan_last) state_next = clr_reply ? ST_DONE : ST_IDLE;
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser)
            OP_EXPLORE: state_next = in_grid(CoordW'(s_tdata[3:0]), CoordW'(s_tdata[7:4])) ?
                                     ST_EXP_RD : ST_INIT_RD;
            OP_SPEED:   state_next = ST_INIT_RD;
            default:    state_next = ST_CLEAR;
          endcase
        end
      end
      ST_EXP_RD:   state_next = ST_EXP_WR;
      ST_EXP_WR:   state_next = ST_NB_CHK;
      ST_NB_CHK: begin
        if (sensed[dcnt] && nb_ok) state_next = ST_NB_WR;
        else if (dcnt == 2'd3) state_next = ST_INIT_RD;
      end
      ST_NB_WR:    state_next = (dcnt == 2'd3) ? ST_INIT_RD : ST_NB_CHK;
      ST_INIT_RD:  state_next = ST_INIT_WR;
      ST_INIT_WR:  if (scan_last) state_next = ST_LVL_RD; else state_next = ST_INIT_RD;
      ST_LVL_RD:   state_next = ST_LVL_EV;
      ST_LVL_EV:   state_next = fl_hit ? ST_FN_CHK : ST_LVL_NEXT;
      ST_FN_CHK: begin
        if (!wreg[dcnt] && nb_ok) state_next = ST_FN_WR;
        else if (dcnt == 2'd3) state_next = ST_LVL_NEXT;
      end
      ST_FN_WR:    state_next = (dcnt == 2'd3) ? ST_LVL_NEXT : ST_FN_CHK;
      ST_LVL_NEXT: begin
        if (!scan_last || assigned) state_next = ST_LVL_RD;
        else state_next = cell_ok ? ST_CH_RD : ST_DONE;
      end
      ST_CH_RD:    state_next = ST_CH_EV;
      ST_CH_EV:    state_next = ST_CH_NB;
      ST_CH_NB: begin
        if (!wreg[dcnt] && nb_ok) state_next = ST_CH_CMP;
        else if (dcnt == 2'd3) state_next = ST_CH_END;
      end
      ST_CH_CMP:   state_next = (dcnt == 2'd3) ? ST_CH_END : ST_CH_NB;
      ST_CH_END: begin
        if (first) state_next = (!bv || op == OP_EXPLORE) ? ST_DONE : ST_CH_RD;
        else state_next = run_more ? ST_CH_RD : ST_DONE;
      end
      ST_DONE:     if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory ports and handshake
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = cell_addr(sc, sr);
    wr_en    = 1'b0;
    wr_addr  = cell_addr(sc, sr);
    wr_entry = q;
    unique case (state)
      ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_entry = '0;
        wr_entry.walls = {sr == '0, sc == LastCol, sr == LastRow, sc == '0};
      end
      ST_IDLE:    s_tready = 1'b1;
      ST_EXP_RD: begin
        rd_en   = 1'b1;
        rd_addr = cell_addr(in_col, in_row);
      end
      ST_EXP_WR: begin
        wr_en    = 1'b1;
        wr_addr  = cell_addr(in_col, in_row);
        wr_entry.walls   = (q.walls & ~sensed) | (wbits & sensed);
        wr_entry.visited = 1'b1;
      end
      ST_NB_CHK, ST_FN_CHK, ST_CH_NB: begin
        rd_addr = cell_addr(nb_c, nb_r);
        if (state == ST_NB_CHK) rd_en = sensed[dcnt] && nb_ok;
        else rd_en = !wreg[dcnt] && nb_ok;
      end
      ST_NB_WR: begin
        wr_en   = 1'b1;
        wr_addr = cell_addr(nb_c, nb_r);
        wr_entry.walls[dcnt ^ 2'd2] = wbits[dcnt];
      end
      ST_INIT_RD, ST_LVL_RD: rd_en = 1'b1;
      ST_INIT_WR: begin
        wr_en = 1'b1;
        wr_entry.flood_dist = Unreached;
        wr_entry.front_a    = src_hit;
        wr_entry.front_b    = 1'b0;
      end
      ST_LVL_EV: begin
        // consume the frontier mark; a cell seen for the first time takes this level
        wr_en = cur_bit;
        if (fl_hit) wr_entry.flood_dist = level;
        if (bank) wr_entry.front_b = 1'b0;
        else wr_entry.front_a = 1'b0;
      end
      ST_FN_WR: begin
        wr_en   = 1'b1;
        wr_addr = cell_addr(nb_c, nb_r);
        if (bank) wr_entry.front_a = 1'b1;
        else wr_entry.front_b = 1'b1;
      end
      ST_CH_RD: begin
        rd_en   = 1'b1;
        rd_addr = cell_addr(pc, pr);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      goal_centre <= 1'b1;
      start_col   <= '0;
      start_row   <= '0;
      sc          <= '0;
      sr          <= '0;
      dcnt        <= '0;
      clr_reply   <= 1'b0;
      bank        <= 1'b0;
      assigned    <= 1'b0;
      first       <= 1'b0;
      bv          <= 1'b0;
      level       <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_GOAL_CENTRE: goal_centre <= cfg_data[0];
          CFG_START_COL:   start_col   <= cfg_data;
          CFG_START_ROW:   start_row   <= cfg_data;
          default: ;
        endcase
      end

      // raster scan position shared by the clear, seed and level sweeps
      if (state == ST_CLEAR || state == ST_INIT_WR || state == ST_LVL_NEXT) begin
        sc <= sc_wrap ? '0 : sc + CoordW'(1);
        if (sc_wrap) sr <= (sr == LastRow) ? '0 : sr + CoordW'(1);
      end

      // direction counter wraps back to west at the end of every sweep of four
      if ((state == ST_NB_CHK && !(sensed[dcnt] && nb_ok)) || state == ST_NB_WR ||
          (state == ST_FN_CHK && !(!wreg[dcnt] && nb_ok)) || state == ST_FN_WR ||
          (state == ST_CH_NB && !(!wreg[dcnt] && nb_ok)) || state == ST_CH_CMP) begin
        dcnt <= dcnt + 2'd1;
      end

      case (state)
        ST_CLEAR: begin
          if (scan_last) begin
            r_dir    <= '0;
            r_run    <= '0;
            r_nopath <= 1'b0;
            r_dist   <= '0;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            op        <= s_tuser;
            in_col    <= CoordW'(s_tdata[3:0]);
            in_row    <= CoordW'(s_tdata[7:4]);
            sensed    <= s_tdata[11:8];
            wbits     <= s_tdata[15:12];
            first     <= 1'b1;
            clr_reply <= 1'b1;
          end
        end
        ST_INIT_WR: begin
          if (scan_last) begin
            bank     <= 1'b0;
            level    <= '0;
            assigned <= 1'b0;
          end
        end
        ST_LVL_EV: begin
          if (fl_hit) begin
            assigned <= 1'b1;
            wreg     <= q.walls;
          end
        end
        ST_LVL_NEXT: begin
          if (scan_last) begin
            if (assigned) begin
              bank     <= ~bank;
              assigned <= 1'b0;
              if (level < MaxLevel) level <= level + 8'd1;
            end else if (!cell_ok) begin
              r_dir    <= '0;
              r_run    <= '0;
              r_nopath <= 1'b1;
              r_dist   <= Unreached;
            end
          end
        end
        ST_CH_EV: begin
          wreg <= q.walls;
          bv   <= 1'b0;
          if (first) r_dist <= q.flood_dist;
        end
        ST_CH_CMP: begin
          if ((op != OP_SPEED || q.visited) && (!bv || q.flood_dist < bd)) begin
            bv   <= 1'b1;
            bd   <= q.flood_dist;
            bdir <= dcnt;
          end
        end
        ST_CH_END: begin
          if (first) begin
            first <= 1'b0;
            if (!bv) begin
              r_dir    <= '0;
              r_run    <= '0;
              r_nopath <= 1'b1;
            end else begin
              r_dir    <= bdir;
              r_run    <= 5'd1;
              r_nopath <= 1'b0;
              pc       <= step_col(pc, bdir);
              pr       <= step_row(pr, bdir);
            end
          end else if (run_more) begin
            r_run <= r_run + 5'd1;
            pc    <= step_col(pc, bdir);
            pr    <= step_row(pr, bdir);
          end
        end
        default: ;
      endcase

      // start the path walk at the current cell
      if (state == ST_LVL_NEXT) begin
        pc <= in_col;
        pr <= in_row;
      end
    end
  end

  // output register: hold a finished result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {r_dist, r_nopath, r_run, r_dir};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for maze_flood_fill_navigator_core: directed items, start/goal
// register sweeps and a random mouse walk. Every result is checked against a map predictor.
// Depends on mffn_pkg and the core RTL.
module testbench;
  import mffn_pkg::*;

  localparam int Cols = 16;
  localparam int Rows = 16;
  localparam int Cells = Cols * Rows;
  localparam logic [1:0] OP_ALT_CLEAR = 2'd3;
  localparam longint CycleLimit = 100_000_000;

  typedef struct packed {
    logic [7:0] cell_dist;
    logic       no_path;
    logic [4:0] run;
    logic [1:0] dir;
  } nav_result_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;

  maze_flood_fill_navigator_core #(.GRID_COLS(Cols), .GRID_ROWS(Rows)) DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [3:0] wall_map[Cells];
  bit         seen_map[Cells];
  logic [7:0] dist_map[Cells];
  bit         front_now[Cells];
  bit         front_next[Cells];
  bit         goal_centre = 1;
  int         src_col = 0;
  int         src_row = 0;

  nav_result_t expected_moves[$];
  nav_result_t last_move;
  bit          quiet = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          moves_checked = 0;
  int          speed_items = 0;
  int          blocked_items = 0;
  longint      cycles = 0;

  function automatic bit on_grid(int c, int r);
    return c >= 0 && c < Cols && r >= 0 && r < Rows;
  endfunction

  function automatic void neighbor(int d, int c, int r, output int nc, output int nr);
    nc = c;
    nr = r;
    case (d)
      DIR_WEST:  nc = c - 1;
      DIR_NORTH: nr = r + 1;
      DIR_EAST:  nc = c + 1;
      default:   nr = r - 1;
    endcase
  endfunction

  function automatic bit edge_is_open(int c, int r, int d);
    int nc, nr;
    if (wall_map[r*Cols+c][d]) return 0;
    neighbor(d, c, r, nc, nr);
    return on_grid(nc, nr);
  endfunction

  function automatic void clear_map();
    for (int i = 0; i < Cells; i++) begin
      wall_map[i] = '0;
      seen_map[i] = 0;
      dist_map[i] = '0;
      front_now[i] = 0;
      front_next[i] = 0;
    end
    for (int c = 0; c < Cols; c++) begin
      wall_map[c][3] = 1'b1;
      wall_map[(Rows-1)*Cols+c][1] = 1'b1;
    end
    for (int r = 0; r < Rows; r++) begin
      wall_map[r*Cols][0] = 1'b1;
      wall_map[r*Cols+Cols-1][2] = 1'b1;
    end
  endfunction

  function automatic void put_wall(int c, int r, int d, bit present);
    if (!on_grid(c, r)) return;
    wall_map[r*Cols+c][d] = present;
  endfunction

  function automatic void flood_distances();
    int nc, nr, i;
    int level = 0;
    bit more = 1;
    for (i = 0; i < Cells; i++) begin
      dist_map[i] = Unreached;
      front_now[i] = 0;
    end
    if (goal_centre) begin
      for (int c = Cols/2-1; c <= Cols/2; c++)
        for (int r = Rows/2-1; r <= Rows/2; r++) front_now[r*Cols+c] = 1;
    end else if (on_grid(src_col, src_row)) begin
      front_now[src_row*Cols+src_col] = 1;
    end
    while (more) begin
      more = 0;
      for (i = 0; i < Cells; i++) front_next[i] = 0;
      for (int r = 0; r < Rows; r++)
        for (int c = 0; c < Cols; c++) begin
          i = r*Cols + c;
          if (front_now[i] && dist_map[i] == Unreached) begin
            dist_map[i] = level[7:0];
            for (int d = 0; d < 4; d++) begin
              if (edge_is_open(c, r, d)) begin
                neighbor(d, c, r, nc, nr);
                if (dist_map[nr*Cols+nc] == Unreached) begin
                  front_next[nr*Cols+nc] = 1;
                  more = 1;
                end
              end
            end
          end
        end
      front_now = front_next;
      if (level < MaxLevel) level++;
    end
  endfunction

  // lowest neighbor distance; ties keep the lower direction; -1 when boxed in
  function automatic int pick_direction(int c, int r, bit visited_only);
    int nc, nr;
    int best = -1;
    int best_dist = 0;
    for (int d = 0; d < 4; d++) begin
      if (edge_is_open(c, r, d)) begin
        neighbor(d, c, r, nc, nr);
        if (!(visited_only && !seen_map[nr*Cols+nc]) &&
            (best < 0 || dist_map[nr*Cols+nc] < best_dist)) begin
          best = d;
          best_dist = dist_map[nr*Cols+nc];
        end
      end
    end
    return best;
  endfunction

  function automatic nav_result_t navigate(logic [1:0] op, int c, int r, logic [3:0] sensed,
                                           logic [3:0] walls);
    nav_result_t res;
    int dir = -1;
    int run = 0;
    int nd, nc, nr, pc, pr;
    res = '0;
    if (op == OP_CLEAR || op == OP_ALT_CLEAR) begin
      clear_map();
      return res;
    end
    if (op == OP_EXPLORE) begin
      seen_map[r*Cols+c] = 1;
      for (int d = 0; d < 4; d++) begin
        if (sensed[d]) begin
          put_wall(c, r, d, walls[d]);
          neighbor(d, c, r, nc, nr);
          put_wall(nc, nr, d ^ 2, walls[d]);
        end
      end
      flood_distances();
      dir = pick_direction(c, r, 0);
      if (dir >= 0) run = 1;
    end else begin
      flood_distances();
      dir = pick_direction(c, r, 1);
      if (dir >= 0) begin
        pc = c;
        pr = r;
        nd = dir;
        while (nd == dir && run < Cols) begin
          run++;
          neighbor(dir, pc, pr, nc, nr);
          pc = nc;
          pr = nr;
          nd = pick_direction(pc, pr, 1);
        end
      end
    end
    res.dir = (dir >= 0) ? dir[1:0] : 2'd0;
    res.run = run[4:0];
    res.no_path = (dir < 0);
    res.cell_dist = dist_map[r*Cols+c];
    return res;
  endfunction

  // receiver: random stalls, none in the quiet stretch
  always @(negedge clk) m_tready <= quiet || ($urandom_range(99) >= 18);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    nav_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      moves_checked++;
      if (expected_moves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", m_tdata);
      end else begin
        want = expected_moves.pop_front();
        if (got.dir !== want.dir || got.run !== want.run || got.no_path !== want.no_path ||
            got.cell_dist !== want.cell_dist) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp dir %0d run %0d no_path %0d dist %0d, %s %0d %s %0d",
                     want.dir, want.run, want.no_path, want.cell_dist,
                     "got dir", got.dir, "run", got.run);
          if (mismatches <= 10)
            $display("          got no_path %0d dist %0d", got.no_path, got.cell_dist);
        end
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_item(logic [1:0] op, int c, int r, logic [3:0] sensed,
                           logic [3:0] walls);
    while (!quiet && $urandom_range(99) < 18) @(negedge clk);
    s_tvalid = 1;
    s_tuser = op;
    s_tdata = {walls, sensed, r[3:0], c[3:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    last_move = navigate(op, c, r, sensed, walls);
    expected_moves.push_back(last_move);
    items_sent++;
    if (op == OP_SPEED) speed_items++;
    if (last_move.no_path) blocked_items++;
    @(negedge clk);
    s_tvalid = 0;
  endtask

  task automatic drain();
    while (expected_moves.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] value);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GOAL_CENTRE: goal_centre = value[0];
      CFG_START_COL:   src_col = value;
      default:         src_row = value;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic test_directed();
    send_item(OP_EXPLORE, 0, 0, 4'h0, 4'h0);
    send_item(OP_EXPLORE, 15, 15, 4'hF, 4'h0);
    send_item(OP_EXPLORE, 6, 6, 4'h0, 4'h0);           // tie north/east
    send_item(OP_EXPLORE, 0, 0, 4'hF, 4'hF);           // boxed in, unreachable
    send_item(OP_SPEED, 0, 0, 4'h0, 4'h0);
    send_item(OP_EXPLORE, 15, 0, 4'hA, 4'h5);
    send_item(OP_EXPLORE, 0, 15, 4'h5, 4'hA);
    send_item(OP_ALT_CLEAR, 9, 3, 4'h3, 4'hC);
    // visit a straight row so a speed run from its west end runs east along it into the centre
    for (int c = 0; c < Cols; c++) send_item(OP_EXPLORE, c, 7, 4'h0, 4'h0);
    send_item(OP_SPEED, 0, 7, 4'h0, 4'h0);
    send_item(OP_CLEAR, 15, 15, 4'hF, 4'hF);
    drain();
  endtask

  task automatic test_start_source();
    int corner[2] = '{0, 15};
    write_reg(CFG_GOAL_CENTRE, 4'd0);
    foreach (corner[k]) begin
      write_reg(CFG_START_COL, 4'(corner[k]));
      write_reg(CFG_START_ROW, 4'(corner[1-k]));
      send_item(OP_EXPLORE, 7, 8, 4'h0, 4'h0);
      send_item(OP_SPEED, 7, 8, 4'h0, 4'h0);
      drain();
    end
    write_reg(CFG_START_COL, 4'd15);
    write_reg(CFG_START_ROW, 4'd15);
    send_item(OP_EXPLORE, 15, 15, 4'h0, 4'h0);
    drain();
  endtask

  task automatic test_random_walk(int count);
    int c, r, pick, nc, nr;
    logic [1:0] op;
    c = 0;
    r = 0;
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count/3 && n < count/2);
      pick = $urandom_range(99);
      if (pick < 4) op = OP_CLEAR;
      else if (pick < 7) op = OP_ALT_CLEAR;
      else if (pick < 27) op = OP_SPEED;
      else op = OP_EXPLORE;
      if ($urandom_range(99) < 25) begin
        c = $urandom_range(Cols-1);
        r = $urandom_range(Rows-1);
      end
      // walls sparse so the flood reaches far
      send_item(op, c, r, 4'($urandom_range(15)),
                4'($urandom_range(15) & $urandom_range(15)));
      if (!last_move.no_path && op != OP_CLEAR && op != OP_ALT_CLEAR) begin
        neighbor(last_move.dir, c, r, nc, nr);
        c = nc;
        r = nr;
      end
      if (n == count/2) begin
        drain();
        write_reg(CFG_GOAL_CENTRE, 4'd1);
      end
    end
    quiet = 0;
    drain();
  endtask

  initial begin
    clear_map();
    repeat (10) @(negedge clk);
    rst = 0;
    test_directed();
    test_start_source();
    test_random_walk(70);
    $display("Covered %0d items (%0d speed runs, %0d boxed-in cells), %0d results checked",
             items_sent, speed_items, blocked_items, moves_checked);
    $display("Flood from centre and from corner start cells, with clears between walks");
    if (mismatches == 0 && expected_moves.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_moves.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
